>>> design/sha256_pkg.sv
`default_nettype none

package sha256_pkg;

    typedef logic [31:0]        t_word;
    typedef logic [15:0][31:0]  t_block;
    typedef logic [7:0][31:0]   t_state8;

    localparam int unsigned NUM_IV_REGS = 4;

    localparam logic [63:0] IV_RESET [NUM_IV_REGS] = '{
        64'h6a09e667bb67ae85, 64'h3c6ef372a54ff53a,
        64'h510e527f9b05688c, 64'h1f83d9ab5be0cd19
    };

    localparam t_word PAD_WORD = 32'h8000_0000;

    localparam t_word K_TABLE [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic t_word big_sigma0(t_word x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic t_word big_sigma1(t_word x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic t_word small_sigma0(t_word x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic t_word small_sigma1(t_word x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

`default_nettype wire

>>> design/sha256_core.sv
`default_nettype none

module sha256_core
    import sha256_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_start,
    input  wire t_block  i_block,
    input  wire t_state8 i_chain,
    output logic         o_done,
    output t_state8      o_work
);

    localparam logic [5:0] LAST_ROUND = 6'd63;

    logic       r_busy;
    logic       r_done;
    logic [5:0] r_round;
    t_block     r_win;
    t_state8    r_work;

    t_word w_new;
    t_word t1;
    t_word t2;
    t_word ch;
    t_word maj;

    always_comb begin
        // window holds W[r..r+15]; W[r+16] computed every round
        w_new = small_sigma1(r_win[14]) + r_win[9] + small_sigma0(r_win[1]) + r_win[0];
        ch    = r_work[6] ^ (r_work[4] & (r_work[5] ^ r_work[6]));
        maj   = (r_work[0] & r_work[1]) | (r_work[2] & (r_work[0] | r_work[1]));
        t1    = r_work[7] + big_sigma1(r_work[4]) + ch + K_TABLE[r_round] + r_win[0];
        t2    = big_sigma0(r_work[0]) + maj;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_round <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_round <= '0;
            end else if (r_busy) begin
                r_round <= r_round + 6'd1;
                if (r_round == LAST_ROUND) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_win  <= i_block;
            r_work <= i_chain;
        end else if (r_busy) begin
            r_win  <= {w_new, r_win[15:1]};
            r_work <= {r_work[6:4], r_work[3] + t1, r_work[2:0], t1 + t2};
        end
    end

    assign o_done = r_done;
    assign o_work = r_work;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("block start while rounds still running");

    a_done_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !i_start && r_round == LAST_ROUND) |=> (r_done && !r_busy))
        else $error("no done after final round");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy && $past(r_busy))
        else $error("done without a finished block");

endmodule

`default_nettype wire

>>> design/sha256_hash_engine_top.sv
// SHA-256 engine: 32-bit message words in, eight digest words out.
// Each 16-word block: the load state starts the core, 64 rounds at one per cycle in the
// shared round unit, then the core result is folded into the chain on done.
// Last word: pad and length words in the pad state plus one or two block passes, then 8 digest items.
// Input is not ready while a block is compressed, padded or the digest drains.
// Synchronous active-low reset loads the standard initial values; no clearing pass.
`default_nettype none

module sha256_hash_engine_top
    import sha256_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input stream
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [39:0] i_s_tdata,   // [31:0] msg_word, [34:32] valid_bytes, rest zero
    input  wire logic        i_s_tlast,   // last_word
    // digest stream
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [31:0]      o_m_tdata,   // [31:0] digest_word
    output logic             o_m_tlast,   // digest_last
    // register writes
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [7:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PAD  = 3'd1;
    localparam logic [2:0] ST_LOAD = 3'd2;
    localparam logic [2:0] ST_COMP = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    localparam logic [3:0] POS_LEN_HI = 4'd14;
    localparam logic [3:0] POS_LEN_LO = 4'd15;
    localparam logic [2:0] OUT_LAST   = 3'd7;

    logic [63:0] r_iv [NUM_IV_REGS];
    t_state8     r_chain;
    t_block      r_blk;

    logic [2:0]  r_state,    n_state;
    logic [3:0]  r_pos,      n_pos;
    logic [63:0] r_len,      n_len;
    logic        r_pend80,   n_pend80;
    logic        r_hi_done,  n_hi_done;
    logic        r_final,    n_final;
    logic        r_pad_act,  n_pad_act;
    logic [2:0]  r_out_idx,  n_out_idx;

    logic        s_acc;
    logic        m_acc;
    logic        push_en;
    t_word       push_data;
    logic        core_start;
    logic        core_done;
    t_state8     core_work;
    logic        chain_add;
    logic        chain_load;
    logic [2:0]  nbytes;
    t_word       msg;

    assign s_acc  = i_s_tvalid && o_s_tready;
    assign m_acc  = o_m_tvalid && i_m_tready;
    assign msg    = i_s_tdata[31:0];
    // counts of five to seven behave as four
    assign nbytes = i_s_tdata[34] ? 3'd4 : i_s_tdata[34:32];

    always_comb begin
        n_state    = r_state;
        n_pos      = r_pos;
        n_len      = r_len;
        n_pend80   = r_pend80;
        n_hi_done  = r_hi_done;
        n_final    = r_final;
        n_pad_act  = r_pad_act;
        n_out_idx  = r_out_idx;
        push_en    = 1'b0;
        push_data  = '0;
        core_start = 1'b0;
        chain_add  = 1'b0;
        chain_load = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (s_acc) begin
                    push_en = 1'b1;
                    if (!i_s_tlast) begin
                        push_data = msg;
                        n_len     = r_len + 64'd32;
                    end else begin
                        n_len     = r_len + {58'b0, nbytes, 3'b000};
                        n_pad_act = 1'b1;
                        case (nbytes)
                            3'd0:    push_data = PAD_WORD;
                            3'd1:    push_data = {msg[31:24], 24'h80_0000};
                            3'd2:    push_data = {msg[31:16], 16'h8000};
                            3'd3:    push_data = {msg[31:8], 8'h80};
                            default: begin
                                push_data = msg;
                                n_pend80  = 1'b1;
                            end
                        endcase
                    end
                    if (r_pos == POS_LEN_LO) begin
                        n_state = ST_LOAD;
                    end else if (i_s_tlast) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                push_en = 1'b1;
                if (r_pend80) begin
                    push_data = PAD_WORD;
                    n_pend80  = 1'b0;
                end else if (r_pos == POS_LEN_HI) begin
                    push_data = r_len[63:32];
                    n_hi_done = 1'b1;
                end else if (r_pos == POS_LEN_LO && r_hi_done) begin
                    push_data = r_len[31:0];
                    n_hi_done = 1'b0;
                    n_final   = 1'b1;
                end
                if (r_pos == POS_LEN_LO) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                core_start = 1'b1;
                n_state    = ST_COMP;
            end
            ST_COMP: begin
                if (core_done) begin
                    chain_add = 1'b1;
                    if (r_final) begin
                        n_state = ST_OUT;
                    end else if (r_pad_act) begin
                        n_state = ST_PAD;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_OUT: begin
                if (m_acc) begin
                    n_out_idx = r_out_idx + 3'd1;
                    if (r_out_idx == OUT_LAST) begin
                        chain_load = 1'b1;
                        n_len      = '0;
                        n_final    = 1'b0;
                        n_pad_act  = 1'b0;
                        n_state    = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase

        if (push_en) begin
            n_pos = r_pos + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_pos     <= '0;
            r_len     <= '0;
            r_pend80  <= 1'b0;
            r_hi_done <= 1'b0;
            r_final   <= 1'b0;
            r_pad_act <= 1'b0;
            r_out_idx <= '0;
        end else begin
            r_state   <= n_state;
            r_pos     <= n_pos;
            r_len     <= n_len;
            r_pend80  <= n_pend80;
            r_hi_done <= n_hi_done;
            r_final   <= n_final;
            r_pad_act <= n_pad_act;
            r_out_idx <= n_out_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_IV_REGS; i++) begin
                r_iv[i] <= IV_RESET[i];
            end
        end else if (i_cfg_valid && i_cfg_index[7:2] == 6'd0) begin
            r_iv[i_cfg_index[1:0]] <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_IV_REGS; i++) begin
                r_chain[2*i]     <= IV_RESET[i][63:32];
                r_chain[2*i + 1] <= IV_RESET[i][31:0];
            end
        end else if (chain_load) begin
            for (int i = 0; i < NUM_IV_REGS; i++) begin
                r_chain[2*i]     <= r_iv[i][63:32];
                r_chain[2*i + 1] <= r_iv[i][31:0];
            end
        end else if (chain_add) begin
            for (int i = 0; i < 8; i++) begin
                r_chain[i] <= r_chain[i] + core_work[i];
            end
        end
    end

    // block gather: new word enters at the top, oldest ends in slot 0
    always_ff @(posedge i_clk) begin
        if (push_en) begin
            r_blk <= {push_data, r_blk[15:1]};
        end
    end

    sha256_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (core_start),
        .i_block (r_blk),
        .i_chain (r_chain),
        .o_done  (core_done),
        .o_work  (core_work)
    );

    assign o_s_tready  = (r_state == ST_IDLE);
    assign o_m_tvalid  = (r_state == ST_OUT);
    assign o_m_tdata   = r_chain[r_out_idx];
    assign o_m_tlast   = (r_out_idx == OUT_LAST);
    assign o_cfg_ready = 1'b1;

    a_full_block_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push_en && r_pos == POS_LEN_LO) |=> (r_state == ST_LOAD && r_pos == 4'd0))
        else $error("full block did not start compression");

    a_digest_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_acc && o_m_tlast) |=> (r_pos == 4'd0 && r_len == 64'd0 && !r_pad_act))
        else $error("message state not cleared after digest");

endmodule

`default_nettype wire

>>> test/sha256_hash_engine_checker.sv
`timescale 1ns / 100ps

module sha256_digest_checker
    import sha256_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [39:0] i_s_tdata,
    input  wire logic        i_s_tlast,
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [31:0] i_m_tdata,
    input  wire logic        i_m_tlast,
    input  wire logic        i_cfg_valid,
    input  wire logic        i_cfg_ready,
    input  wire logic [7:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data,
    output int               o_pending,
    output int               o_errors
);

    logic [63:0] iv_reg [NUM_IV_REGS];
    t_word       chain [8];
    t_word       blk [16];
    int unsigned fill;
    logic [63:0] msg_bits;
    t_word       digest_q [$];
    logic        digest_last_q [$];
    int          digest_idx;

    function automatic t_word ror(t_word x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void reload_chain();
        for (int k = 0; k < NUM_IV_REGS; k++) begin
            chain[2*k]     = iv_reg[k][63:32];
            chain[2*k + 1] = iv_reg[k][31:0];
        end
    endfunction

    function automatic void fold_block();
        t_word sched [64];
        t_word a, b, c, d, e, f, g, h, t1, t2, s0, s1;
        for (int i = 0; i < 16; i++)
            sched[i] = blk[i];
        for (int i = 16; i < 64; i++) begin
            s0 = ror(sched[i-15], 7) ^ ror(sched[i-15], 18) ^ (sched[i-15] >> 3);
            s1 = ror(sched[i-2], 17) ^ ror(sched[i-2], 19) ^ (sched[i-2] >> 10);
            sched[i] = s1 + sched[i-7] + s0 + sched[i-16];
        end
        a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
        e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
        for (int i = 0; i < 64; i++) begin
            t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
                 + K_TABLE[i] + sched[i];
            t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
        chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
    endfunction

    function automatic void absorb(t_word w);
        blk[fill] = w;
        fill++;
        if (fill == 16) begin
            fold_block();
            fill = 0;
        end
    endfunction

    function automatic void take_item(t_word w, logic [2:0] vb, logic last);
        int    nbytes;
        t_word keep;
        if (!last) begin
            // byte count is don't-care on inner words
            msg_bits += 64'd32;
            absorb(w);
        end else begin
            nbytes = (vb > 3'd4) ? 4 : int'(vb);
            msg_bits += 64'(nbytes * 8);
            if (nbytes == 4) begin
                absorb(w);
                absorb(PAD_WORD);
            end else begin
                keep = (nbytes == 0) ? '0 : ('1 << (32 - 8 * nbytes));
                absorb((w & keep) | (PAD_WORD >> (8 * nbytes)));
            end
            while (fill != 14)
                absorb('0);
            absorb(msg_bits[63:32]);
            absorb(msg_bits[31:0]);
            for (int k = 0; k < 8; k++) begin
                digest_q.push_back(chain[k]);
                digest_last_q.push_back(k == 7);
            end
            reload_chain();
            fill = 0;
            msg_bits = '0;
        end
    endfunction

    always @(posedge i_clk) begin
        t_word exp_word;
        logic  exp_last;
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_IV_REGS; k++)
                iv_reg[k] = IV_RESET[k];
            reload_chain();
            fill = 0;
            msg_bits = '0;
            digest_q.delete();
            digest_last_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready && i_cfg_index < NUM_IV_REGS)
                iv_reg[i_cfg_index[1:0]] = i_cfg_data;
            if (i_s_tvalid && i_s_tready)
                take_item(i_s_tdata[31:0], i_s_tdata[34:32], i_s_tlast);
            if (i_m_tvalid === 1'b1 && i_m_tready) begin
                if (digest_q.size() == 0) begin
                    o_errors++;
                    $display("%0t: digest item with none expected, got %h last %b",
                             $time, i_m_tdata, i_m_tlast);
                end else begin
                    exp_word = digest_q.pop_front();
                    exp_last = digest_last_q.pop_front();
                    if (i_m_tdata !== exp_word || i_m_tlast !== exp_last) begin
                        o_errors++;
                        $display("%0t: digest item %0d expected %h last %b, got %h last %b",
                                 $time, digest_idx, exp_word, exp_last,
                                 i_m_tdata, i_m_tlast);
                    end
                end
                digest_idx++;
            end
        end
        o_pending = digest_q.size();
    end

endmodule

>>> test/sha256_hash_engine_top_test.sv
`timescale 1ns / 100ps

module sha256_hash_engine_top_test
    import sha256_pkg::*;
;

    localparam logic [7:0] REG_IV_01 = 8'd0;
    localparam logic [7:0] REG_IV_23 = 8'd1;
    localparam logic [7:0] REG_IV_45 = 8'd2;
    localparam logic [7:0] REG_IV_67 = 8'd3;
    localparam int         SETTLE_CYCLES = 200;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    wire         s_tready;
    logic [39:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    wire         m_tvalid;
    logic        m_tready = 1'b0;
    wire  [31:0] m_tdata;
    wire         m_tlast;
    logic        cfg_valid = 1'b0;
    wire         cfg_ready;
    logic [7:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;
    int          pending;
    int          errors;

    int unsigned words_sent = 0;
    int unsigned burst_left = 0;
    logic [7:0]  stall_phase = '0;
    int unsigned stall_mode = 0;

    always #5 clk = ~clk;

    sha256_hash_engine_top u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tlast   (s_tlast),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tlast   (m_tlast),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    sha256_digest_checker u_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tlast   (s_tlast),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .i_m_tlast   (m_tlast),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_pending   (pending),
        .o_errors    (errors)
    );

    // digest side back-pressure: mode is redrawn whenever the low six phase bits are zero
    always @(negedge clk) begin
        stall_phase <= stall_phase + 8'd1;
        if (stall_phase[5:0] == 6'd0)
            stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= stall_phase[1];
            2:       m_tready <= 1'($urandom_range(0, 1));
            default: m_tready <= (stall_phase[3:0] > 4'd11);
        endcase
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_word(input t_word w, input logic [2:0] vb, input logic last);
        int unsigned gap;
        if (burst_left == 0) begin
            s_tvalid = 1'b0;
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap) @(negedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
        end
        s_tvalid = 1'b1;
        s_tdata  = {5'b0, vb, w};
        s_tlast  = last;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
        burst_left--;
        words_sent++;
    endtask

    task automatic drain();
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [63:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic new_ivs(input logic [63:0] r01, input logic [63:0] r23,
                           input logic [63:0] r45, input logic [63:0] r67);
        drain();
        repeat (SETTLE_CYCLES) @(negedge clk);
        write_reg(REG_IV_01, r01);
        write_reg(REG_IV_23, r23);
        write_reg(REG_IV_45, r45);
        write_reg(REG_IV_67, r67);
    endtask

    function automatic t_word rand_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_message();
        int unsigned len;
        int unsigned pick;
        logic [2:0]  last_vb;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            len = $urandom_range(1, 12);
        else if (pick < 8)
            len = $urandom_range(13, 18);   // around the one/two pad block split
        else if (pick == 8)
            len = $urandom_range(29, 34);
        else
            len = $urandom_range(40, 64);
        for (int k = 1; k < len; k++)
            send_word(rand_word(), 3'($urandom_range(0, 7)), 1'b0);
        last_vb = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7))
                                              : 3'($urandom_range(1, 4));
        send_word(rand_word(), last_vb, 1'b1);
        if ($urandom_range(0, 5) == 0)
            drain();
    endtask

    task automatic run_messages(input int unsigned goal);
        int unsigned start;
        start = words_sent;
        while (words_sent - start < goal)
            send_message();
    endtask

    initial begin
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // empty message, pad byte over nonzero unused bytes
        send_word(32'hdeadbeef, 3'd0, 1'b1);
        // "abc" with a stray trailing byte
        send_word(32'h616263ff, 3'd3, 1'b1);
        send_word(32'hffffffff, 3'd5, 1'b0);
        send_word(32'hffffffff, 3'd1, 1'b1);
        send_word(32'h00000000, 3'd0, 1'b0);
        send_word(32'h12345678, 3'd7, 1'b1);
        // zero-byte last word ends the message at the word before
        send_word(32'hffffffff, 3'd6, 1'b0);
        send_word(32'h00000000, 3'd0, 1'b1);
        send_word(32'ha5a5a5a5, 3'd4, 1'b1);
        send_word(32'h5a5a5a5a, 3'd2, 1'b1);
        // 56 bytes: length no longer fits, needs a second pad block
        for (int k = 0; k < 13; k++)
            send_word($urandom, (k == 6) ? 3'd3 : 3'd4, 1'b0);
        send_word($urandom, 3'd4, 1'b1);

        new_ivs('1, '1, '1, '1);
        run_messages(80);
        new_ivs('0, '0, '0, '0);
        run_messages(80);
        new_ivs({$urandom, $urandom}, {$urandom, $urandom},
                {$urandom, $urandom}, {$urandom, $urandom});
        run_messages(90);
        new_ivs(IV_RESET[0], IV_RESET[1], IV_RESET[2], IV_RESET[3]);
        run_messages(96);

        drain();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> sim.f
design/sha256_pkg.sv
design/sha256_core.sv
design/sha256_hash_engine_top.sv
test/sha256_hash_engine_checker.sv
test/sha256_hash_engine_top_test.sv
